FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker file dsu_checker.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, quiet while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Next-cycle implication that is also checked through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/core/dsu_pkg.sv
// ---------------------------------------------------------------------------
// dsu_pkg
// Types and constants of the disjoint-set union-find store.
// ---------------------------------------------------------------------------
package dsu_pkg;

  localparam int ELEM_W  = 10;
  localparam int RANK_W  = 4;
  localparam int CMD_W   = 2;
  localparam int APB_W   = 32;
  localparam int PADDR_W = 3;

  localparam logic [RANK_W-1:0] RANK_MAX         = 4'd15;
  localparam logic [ELEM_W-1:0] ELEM_COUNT_RESET = 10'd1023;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_FIND        = 2'd0;
  localparam logic [CMD_W-1:0] CMD_UNION_RANK  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_UNION_INDEX = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 2'd3;

  // Register index (paddr bit 2)
  localparam logic REG_ELEMENT_COUNT = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ELEM_W-1:0] first_element;
    logic [ELEM_W-1:0] second_element;
  } in_item_t;

  typedef struct packed {
    logic [ELEM_W-1:0] root_index;
    logic [ELEM_W-1:0] classes_left;
    logic              merged;
    logic              bad_index;
  } out_item_t;

endpackage

FILE: rtl/core/dsu_cfg.sv
// ---------------------------------------------------------------------------
// dsu_cfg
// APB-style register slice holding the element count.
// ---------------------------------------------------------------------------
module dsu_cfg
  import dsu_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready,
  output logic [ELEM_W-1:0]  element_count
);

  logic [ELEM_W-1:0] element_count_r;
  logic [ELEM_W-1:0] element_count_nxt;

  always_comb begin
    element_count_nxt = element_count_r;
    if (psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT)) begin
      element_count_nxt = pwdata[ELEM_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      element_count_r <= ELEM_COUNT_RESET;
    end else begin
      element_count_r <= element_count_nxt;
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_ELEMENT_COUNT) begin
      prdata = {{(APB_W-ELEM_W){1'b0}}, element_count_r};
    end
  end

  assign pready        = 1'b1;
  assign element_count = element_count_r;

endmodule

FILE: rtl/core/dsu_store.sv
// ---------------------------------------------------------------------------
// dsu_store
// Simple dual-port RAM for parent and rank entries, registered read.
// ---------------------------------------------------------------------------
module dsu_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10,
  parameter int DATA_W = 14
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/core/disjoint_set_union_find.sv
// ---------------------------------------------------------------------------
// disjoint_set_union_find
// Union-find store with full path compression, union by rank and
// index-ordered union, held in one parent/rank RAM.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_data and raise start; the beat is taken at a
//   clock edge where start is high and busy is low. Commands are find,
//   union by rank, union keeping the smaller root index, and clear.
//   Result channel: each command gives exactly one beat on out_data, marked
//   by out_valid for one cycle. The receiver cannot stall; take it then.
//   Configuration: APB-style port, element_count at byte address 0.
//   Write it only while the block is idle; range checks use it at once, the
//   class count takes it at the next clear.
// Steps from accepted beat to result, one RAM read per walk step:
//   bad index       : answered at the accepting edge, busy stays low.
//   find            : walk up to the root, then rewrite each path node to it.
//   union           : both walks as for find; a shared root is answered, else
//                     one link write, and a rank write when the new root's rank rises.
//   clear           : entries reset to self, rank 0, one entry rewritten a cycle.
// Throughput: busy drops at the edge that raises out_valid, so the next beat
//   may be taken at the result edge; a bad index frees the port at once.
// Reset: a clearing pass rewrites the RAM with busy high and no result;
//   configuration writes are taken meanwhile.
// ---------------------------------------------------------------------------
module disjoint_set_union_find
  import dsu_pkg::*;
#(
  parameter int MAX_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // command channel
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_data,
  // result channel
  output logic               out_valid,
  output out_item_t          out_data,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int DATA_W = RANK_W + IDX_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ELEMENTS - 1);

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [IDX_W-1:0]  parent;
  } entry_t;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_CLR    = 7'b0000010,
    S_WALK   = 7'b0000100,
    S_PRESS  = 7'b0001000,
    S_SECOND = 7'b0010000,
    S_LINK   = 7'b0100000,
    S_RAISE  = 7'b1000000
  } state_t;

  // -------------------------------------------------------------------------
  // Configuration register
  // -------------------------------------------------------------------------
  logic [ELEM_W-1:0] element_count;

  dsu_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .element_count (element_count)
  );

  // -------------------------------------------------------------------------
  // Parent/rank RAM
  // -------------------------------------------------------------------------
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_entry;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [DATA_W-1:0] rd_word;
  entry_t            rd_entry;

  dsu_store #(
    .DEPTH  (MAX_ELEMENTS),
    .ADDR_W (IDX_W),
    .DATA_W (DATA_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_entry = entry_t'(rd_word);

  // -------------------------------------------------------------------------
  // Sequencer registers
  // -------------------------------------------------------------------------
  state_t            state_r,       state_nxt;
  logic [CMD_W-1:0]  cmd_r,         cmd_nxt;
  logic [IDX_W-1:0]  a_r,           a_nxt;
  logic [IDX_W-1:0]  b_r,           b_nxt;
  logic              phase_r,       phase_nxt;     // 0: first walk, 1: second
  logic [IDX_W-1:0]  cur_r,         cur_nxt;
  logic [IDX_W-1:0]  root_r,        root_nxt;
  logic [RANK_W-1:0] rank_r,        rank_nxt;
  logic [IDX_W-1:0]  ra_r,          ra_nxt;
  logic [RANK_W-1:0] ra_rank_r,     ra_rank_nxt;
  logic [IDX_W-1:0]  rb_r,          rb_nxt;
  logic [RANK_W-1:0] rb_rank_r,     rb_rank_nxt;
  logic [IDX_W-1:0]  clr_addr_r,    clr_addr_nxt;
  logic              clr_reply_r,   clr_reply_nxt;
  logic [ELEM_W-1:0] class_count_r, class_count_nxt;
  logic              out_valid_r,   out_valid_nxt;
  out_item_t         out_data_r,    out_data_nxt;

  logic              accept;
  logic              first_ok;
  logic              second_ok;
  logic [IDX_W-1:0]  first_idx;
  logic [IDX_W-1:0]  second_idx;
  logic              fin;
  logic [IDX_W-1:0]  fin_root;
  logic [RANK_W-1:0] fin_rank;
  logic [ELEM_W-1:0] count_dec;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign first_idx  = IDX_W'(in_data.first_element);
  assign second_idx = IDX_W'(in_data.second_element);
  assign first_ok   = (in_data.first_element <= element_count) &&
                      (32'(in_data.first_element) < MAX_ELEMENTS);
  assign second_ok  = (in_data.second_element <= element_count) &&
                      (32'(in_data.second_element) < MAX_ELEMENTS);
  // saturate at zero
  assign count_dec  = (class_count_r == '0) ? '0 : class_count_r - 1'b1;

  always_comb begin
    state_nxt       = state_r;
    cmd_nxt         = cmd_r;
    a_nxt           = a_r;
    b_nxt           = b_r;
    phase_nxt       = phase_r;
    cur_nxt         = cur_r;
    root_nxt        = root_r;
    rank_nxt        = rank_r;
    ra_nxt          = ra_r;
    ra_rank_nxt     = ra_rank_r;
    rb_nxt          = rb_r;
    rb_rank_nxt     = rb_rank_r;
    clr_addr_nxt    = clr_addr_r;
    clr_reply_nxt   = clr_reply_r;
    class_count_nxt = class_count_r;
    out_valid_nxt   = 1'b0;
    out_data_nxt    = out_data_r;
    wr_en           = 1'b0;
    wr_addr         = cur_r;
    wr_entry        = '{rank: rd_entry.rank, parent: root_r};
    rd_en           = 1'b0;
    rd_addr         = cur_r;
    fin             = 1'b0;
    fin_root        = root_r;
    fin_rank        = rank_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt = in_data.cmd;
          a_nxt   = first_idx;
          b_nxt   = second_idx;
          if (in_data.cmd == CMD_CLEAR) begin
            // sweep the RAM; the count takes the current element count now
            state_nxt       = S_CLR;
            clr_addr_nxt    = '0;
            clr_reply_nxt   = 1'b1;
            class_count_nxt = element_count;
          end else if (!first_ok || (in_data.cmd != CMD_FIND && !second_ok)) begin
            // drop the command, answer at once
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{root_index: '0, classes_left: class_count_r,
                              merged: 1'b0, bad_index: 1'b1};
          end else begin
            rd_en     = 1'b1;
            rd_addr   = first_idx;
            cur_nxt   = first_idx;
            phase_nxt = 1'b0;
            state_nxt = S_WALK;
          end
        end
      end

      S_CLR: begin
        wr_en    = 1'b1;
        wr_addr  = clr_addr_r;
        wr_entry = '{rank: '0, parent: clr_addr_r};
        if (clr_addr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
          if (clr_reply_r) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '{root_index: '0, classes_left: class_count_r,
                              merged: 1'b0, bad_index: 1'b0};
          end
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end

      S_WALK: begin
        // first pass: follow parents up to the root
        if (rd_entry.parent == cur_r) begin
          root_nxt = cur_r;
          rank_nxt = rd_entry.rank;
          if ((phase_r ? b_r : a_r) == cur_r) begin
            fin      = 1'b1;
            fin_root = cur_r;
            fin_rank = rd_entry.rank;
          end else begin
            rd_en     = 1'b1;
            rd_addr   = phase_r ? b_r : a_r;
            cur_nxt   = phase_r ? b_r : a_r;
            state_nxt = S_PRESS;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_entry.parent;
          cur_nxt = rd_entry.parent;
        end
      end

      S_PRESS: begin
        // second pass: point each node on the path at the root, keep its rank
        wr_en    = 1'b1;
        wr_addr  = cur_r;
        wr_entry = '{rank: rd_entry.rank, parent: root_r};
        if (rd_entry.parent == root_r) begin
          fin = 1'b1;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rd_entry.parent;
          cur_nxt = rd_entry.parent;
        end
      end

      S_SECOND: begin
        // start of the second walk, in a state of its own once the first walk and its compression writes are done
        rd_en     = 1'b1;
        rd_addr   = b_r;
        cur_nxt   = b_r;
        state_nxt = S_WALK;
      end

      S_LINK: begin
        wr_en           = 1'b1;
        class_count_nxt = count_dec;
        out_data_nxt    = '{root_index: '0, classes_left: count_dec,
                            merged: 1'b1, bad_index: 1'b0};
        state_nxt       = S_IDLE;
        out_valid_nxt   = 1'b1;
        if (cmd_r == CMD_UNION_RANK) begin
          if (ra_rank_r < rb_rank_r) begin
            wr_addr                 = ra_r;
            wr_entry                = '{rank: ra_rank_r, parent: rb_r};
            out_data_nxt.root_index = ELEM_W'(rb_r);
          end else begin
            wr_addr                 = rb_r;
            wr_entry                = '{rank: rb_rank_r, parent: ra_r};
            out_data_nxt.root_index = ELEM_W'(ra_r);
            if (ra_rank_r == rb_rank_r && ra_rank_r != RANK_MAX) begin
              // hold the result for the rank update
              state_nxt     = S_RAISE;
              out_valid_nxt = 1'b0;
            end
          end
        end else begin
          if (ra_r < rb_r) begin
            wr_addr                 = rb_r;
            wr_entry                = '{rank: rb_rank_r, parent: ra_r};
            out_data_nxt.root_index = ELEM_W'(ra_r);
          end else begin
            wr_addr                 = ra_r;
            wr_entry                = '{rank: ra_rank_r, parent: rb_r};
            out_data_nxt.root_index = ELEM_W'(rb_r);
          end
        end
      end

      S_RAISE: begin
        wr_en         = 1'b1;
        wr_addr       = ra_r;
        wr_entry      = '{rank: ra_rank_r + 1'b1, parent: ra_r};
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of a walk: answer a find or a union within one class, or move the union on
    if (fin) begin
      if (cmd_r == CMD_FIND) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{root_index: ELEM_W'(fin_root), classes_left: class_count_r,
                          merged: 1'b0, bad_index: 1'b0};
        state_nxt     = S_IDLE;
      end else if (!phase_r) begin
        ra_nxt      = fin_root;
        ra_rank_nxt = fin_rank;
        phase_nxt   = 1'b1;
        state_nxt   = S_SECOND;
      end else if (fin_root == ra_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{root_index: ELEM_W'(ra_r), classes_left: class_count_r,
                          merged: 1'b0, bad_index: 1'b0};
        state_nxt     = S_IDLE;
      end else begin
        rb_nxt      = fin_root;
        rb_rank_nxt = fin_rank;
        state_nxt   = S_LINK;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLR;
      clr_addr_r    <= '0;
      clr_reply_r   <= 1'b0;
      class_count_r <= ELEM_COUNT_RESET;
      out_valid_r   <= 1'b0;
      phase_r       <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      clr_addr_r    <= clr_addr_nxt;
      clr_reply_r   <= clr_reply_nxt;
      class_count_r <= class_count_nxt;
      out_valid_r   <= out_valid_nxt;
      phase_r       <= phase_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    cur_r      <= cur_nxt;
    root_r     <= root_nxt;
    rank_r     <= rank_nxt;
    ra_r       <= ra_nxt;
    ra_rank_r  <= ra_rank_nxt;
    rb_r       <= rb_nxt;
    rb_rank_r  <= rb_rank_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/dsu_checker.sv
// ---------------------------------------------------------------------------
// dsu_checker
// Port-level assertions for the union-find store, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dsu_checker
  import dsu_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_data,
  input logic      out_valid,
  input out_item_t out_data
);

  // reset starts the clearing pass
  `ASSERT_NEXT_ALWAYS(a_sweep_after_reset, clk, !rst_n, busy)

  // a clear beat always sweeps
  `ASSERT_NEXT(a_clear_busy, clk, rst_n, start && !busy && in_data.cmd == CMD_CLEAR, busy)

  // a rejected command reports no root and no merge
  `ASSERT_IMPL(a_bad_clean, clk, rst_n, out_valid && out_data.bad_index, out_data.root_index == '0 && !out_data.merged)

  // no result without a command under way
  `ASSERT_IMPL(a_out_caused, clk, rst_n, out_valid, $past(busy) || $past(start))

endmodule

bind disjoint_set_union_find dsu_checker u_dsu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
